// ----- hw/rtl/tcst_pkg.sv -----
// Shared types and constants for the triangle camera-space transform.
// Holds stage enables, register indexes and pipeline geometry; depends on nothing.
`default_nettype none

package tcst_pkg;

	localparam int LANES       = 3;
	localparam int LANE_STAGES = 7;
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_X   = 3'd0,
		REG_OFFSET_Y   = 3'd1,
		REG_OFFSET_Z   = 3'd2,
		REG_YAW_TRIG   = 3'd3,
		REG_PITCH_TRIG = 3'd4,
		REG_ROLL_TRIG  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic mul;
		logic sum;
	} rot_en_t;

	typedef struct packed {
		logic    add;
		rot_en_t yaw;
		rot_en_t pitch;
		rot_en_t roll;
	} ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcst_rot.sv -----
// Two-stage planar rotation: four products, then rounded and saturated sums.
// Depends on tcst_pkg for the stage enable type.
`default_nettype none

module tcst_rot #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                          clk,
	input  tcst_pkg::rot_en_t             en,
	input  logic signed [COORD_WIDTH-1:0] a,
	input  logic signed [COORD_WIDTH-1:0] b,
	input  logic signed [TRIG_WIDTH-1:0]  c,
	input  logic signed [TRIG_WIDTH-1:0]  s,
	output logic signed [COORD_WIDTH-1:0] p,
	output logic signed [COORD_WIDTH-1:0] q
);

	localparam int PW = COORD_WIDTH + TRIG_WIDTH;
	localparam int SW = PW + 1;
	localparam int FS = TRIG_WIDTH - 2;
	localparam int RW = SW - FS;
	localparam logic signed [SW-1:0] HALF = {{(SW-FS){1'b0}}, 1'b1, {(FS-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [PW-1:0]          ac_s1, bs_s1, as_s1, bc_s1;
	logic signed [SW-1:0]          dif, sum;
	logic signed [RW-1:0]          dif_r, sum_r;
	logic signed [COORD_WIDTH-1:0] p_s2, q_s2;

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
		if (&v[RW-1:COORD_WIDTH-1] || ~|v[RW-1:COORD_WIDTH-1])
			return v[COORD_WIDTH-1:0];
		return v[RW-1] ? MINV : MAXV;
	endfunction

	always_comb begin
		dif   = SW'(ac_s1) - SW'(bs_s1) + HALF;
		sum   = SW'(as_s1) + SW'(bc_s1) + HALF;
		dif_r = RW'(dif >>> FS);
		sum_r = RW'(sum >>> FS);
	end

	always_ff @(posedge clk) begin
		if (en.mul) begin
			ac_s1 <= PW'(a) * PW'(c);
			bs_s1 <= PW'(b) * PW'(s);
			as_s1 <= PW'(a) * PW'(s);
			bc_s1 <= PW'(b) * PW'(c);
		end
		if (en.sum) begin
			p_s2 <= sat(dif_r);
			q_s2 <= sat(sum_r);
		end
	end

	assign p = p_s2;
	assign q = q_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/tcst_lane.sv -----
// One vertex lane: offset add, then yaw, pitch and roll rotations in turn.
// Depends on tcst_pkg (stage enables) and tcst_rot.
`default_nettype none

module tcst_lane #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                          clk,
	input  tcst_pkg::ctrl_t               ctrl,
	input  logic signed [COORD_WIDTH-1:0] x,
	input  logic signed [COORD_WIDTH-1:0] y,
	input  logic signed [COORD_WIDTH-1:0] z,
	input  logic signed [COORD_WIDTH-1:0] off_x,
	input  logic signed [COORD_WIDTH-1:0] off_y,
	input  logic signed [COORD_WIDTH-1:0] off_z,
	input  logic [2*TRIG_WIDTH-1:0]       yaw_trig,
	input  logic [2*TRIG_WIDTH-1:0]       pitch_trig,
	input  logic [2*TRIG_WIDTH-1:0]       roll_trig,
	output logic signed [COORD_WIDTH-1:0] rx,
	output logic signed [COORD_WIDTH-1:0] ry,
	output logic signed [COORD_WIDTH-1:0] rz
);

	localparam logic signed [COORD_WIDTH-1:0] MAXV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MINV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic signed [COORD_WIDTH:0]   sx, sy, sz;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic signed [COORD_WIDTH-1:0] x_s3, z_s3, y_s2, y_s3;
	logic signed [COORD_WIDTH-1:0] z_s5, y_s5, x_s4, x_s5;
	logic signed [COORD_WIDTH-1:0] x_s7, y_s7, z_s6, z_s7;

	function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [COORD_WIDTH:0] v);
		if (v[COORD_WIDTH] == v[COORD_WIDTH-1])
			return v[COORD_WIDTH-1:0];
		return v[COORD_WIDTH] ? MINV : MAXV;
	endfunction

	always_comb begin
		sx = (COORD_WIDTH+1)'(x) + (COORD_WIDTH+1)'(off_x);
		sy = (COORD_WIDTH+1)'(y) + (COORD_WIDTH+1)'(off_y);
		sz = (COORD_WIDTH+1)'(z) + (COORD_WIDTH+1)'(off_z);
	end

	always_ff @(posedge clk) begin
		if (ctrl.add) begin
			x_s1 <= sat(sx);
			y_s1 <= sat(sy);
			z_s1 <= sat(sz);
		end
		if (ctrl.yaw.mul)   y_s2 <= y_s1;
		if (ctrl.yaw.sum)   y_s3 <= y_s2;
		if (ctrl.pitch.mul) x_s4 <= x_s3;
		if (ctrl.pitch.sum) x_s5 <= x_s4;
		if (ctrl.roll.mul)  z_s6 <= z_s5;
		if (ctrl.roll.sum)  z_s7 <= z_s6;
	end

	tcst_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_yaw (
		.clk (clk),
		.en  (ctrl.yaw),
		.a   (x_s1),
		.b   (z_s1),
		.c   ($signed(yaw_trig[2*TRIG_WIDTH-1:TRIG_WIDTH])),
		.s   ($signed(yaw_trig[TRIG_WIDTH-1:0])),
		.p   (x_s3),
		.q   (z_s3)
	);

	tcst_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_pitch (
		.clk (clk),
		.en  (ctrl.pitch),
		.a   (z_s3),
		.b   (y_s3),
		.c   ($signed(pitch_trig[2*TRIG_WIDTH-1:TRIG_WIDTH])),
		.s   ($signed(pitch_trig[TRIG_WIDTH-1:0])),
		.p   (z_s5),
		.q   (y_s5)
	);

	tcst_rot #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_roll (
		.clk (clk),
		.en  (ctrl.roll),
		.a   (x_s5),
		.b   (y_s5),
		.c   ($signed(roll_trig[2*TRIG_WIDTH-1:TRIG_WIDTH])),
		.s   ($signed(roll_trig[TRIG_WIDTH-1:0])),
		.p   (x_s7),
		.q   (y_s7)
	);

	assign rx = x_s7;
	assign ry = y_s7;
	assign rz = z_s7;

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_camera_space_transform_top.sv -----
// Triangle camera-space transform: three vertex lanes, stage control and output register.
// Depends on tcst_pkg, tcst_lane and tcst_rot.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one triangle word per cycle while in_ready
//   is high: three vertices in object space, signed Q16.16 at the default width.
//   Output channel (out_valid/out_ready) returns the camera-space triangle.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   offsets and the yaw, pitch and roll cosine/sine pairs; it is always ready.
//   The user must write it only while no triangle is in flight; the block does not enforce this.
//   An accepted word passes through the offset stage, two stages per rotation
//   (products, then sums) and then the output register.
//   Throughput: one triangle per cycle while the receiver does not stall, set by
//   the three lanes each having their own four multipliers per rotation stage.
//   Reset clears all stage valid flags and sets offsets to zero and every
//   rotation to cosine one, sine zero.
//   When the receiver stalls, the output word holds and bubbles in the pipeline
//   close up; input is refused only once every stage holds a word.
`default_nettype none

module triangle_camera_space_transform_top #(
	parameter int COORD_WIDTH = 32,
	parameter int TRIG_WIDTH  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [COORD_WIDTH-1:0]        in_ax,
	input  logic signed [COORD_WIDTH-1:0]        in_ay,
	input  logic signed [COORD_WIDTH-1:0]        in_az,
	input  logic signed [COORD_WIDTH-1:0]        in_bx,
	input  logic signed [COORD_WIDTH-1:0]        in_by,
	input  logic signed [COORD_WIDTH-1:0]        in_bz,
	input  logic signed [COORD_WIDTH-1:0]        in_cx,
	input  logic signed [COORD_WIDTH-1:0]        in_cy,
	input  logic signed [COORD_WIDTH-1:0]        in_cz,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [COORD_WIDTH-1:0]        out_ax,
	output logic signed [COORD_WIDTH-1:0]        out_ay,
	output logic signed [COORD_WIDTH-1:0]        out_az,
	output logic signed [COORD_WIDTH-1:0]        out_bx,
	output logic signed [COORD_WIDTH-1:0]        out_by,
	output logic signed [COORD_WIDTH-1:0]        out_bz,
	output logic signed [COORD_WIDTH-1:0]        out_cx,
	output logic signed [COORD_WIDTH-1:0]        out_cy,
	output logic signed [COORD_WIDTH-1:0]        out_cz,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tcst_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [((COORD_WIDTH > 2*TRIG_WIDTH) ? COORD_WIDTH : 2*TRIG_WIDTH)-1:0] cfg_data
);

	localparam int NS = tcst_pkg::LANE_STAGES;

	logic signed [COORD_WIDTH-1:0] off_x_q, off_y_q, off_z_q;
	logic [2*TRIG_WIDTH-1:0]       yaw_q, pitch_q, roll_q;
	logic [NS:1]                   vld_q;
	logic [NS+1:1]                 free;
	logic                          out_valid_q;
	tcst_pkg::ctrl_t               ctrl;

	logic signed [COORD_WIDTH-1:0] vin  [tcst_pkg::LANES][3];
	logic signed [COORD_WIDTH-1:0] vout [tcst_pkg::LANES][3];
	logic signed [COORD_WIDTH-1:0] res_q [tcst_pkg::LANES][3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			off_z_q <= '0;
			yaw_q   <= {2'b01, {(2*TRIG_WIDTH-2){1'b0}}};
			pitch_q <= {2'b01, {(2*TRIG_WIDTH-2){1'b0}}};
			roll_q  <= {2'b01, {(2*TRIG_WIDTH-2){1'b0}}};
		end else if (cfg_valid) begin
			case (cfg_index)
				tcst_pkg::REG_OFFSET_X:   off_x_q <= $signed(cfg_data[COORD_WIDTH-1:0]);
				tcst_pkg::REG_OFFSET_Y:   off_y_q <= $signed(cfg_data[COORD_WIDTH-1:0]);
				tcst_pkg::REG_OFFSET_Z:   off_z_q <= $signed(cfg_data[COORD_WIDTH-1:0]);
				tcst_pkg::REG_YAW_TRIG:   yaw_q   <= cfg_data[2*TRIG_WIDTH-1:0];
				tcst_pkg::REG_PITCH_TRIG: pitch_q <= cfg_data[2*TRIG_WIDTH-1:0];
				tcst_pkg::REG_ROLL_TRIG:  roll_q  <= cfg_data[2*TRIG_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the stage after it advances
	always_comb begin
		free[NS+1] = !out_valid_q || out_ready;
		for (int k = NS; k >= 1; k--)
			free[k] = !vld_q[k] || free[k+1];
		ctrl.add       = free[1];
		ctrl.yaw.mul   = free[2];
		ctrl.yaw.sum   = free[3];
		ctrl.pitch.mul = free[4];
		ctrl.pitch.sum = free[5];
		ctrl.roll.mul  = free[6];
		ctrl.roll.sum  = free[7];
	end

	assign in_ready = free[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (free[1])
				vld_q[1] <= in_valid;
			for (int k = 2; k <= NS; k++)
				if (free[k])
					vld_q[k] <= vld_q[k-1];
			if (free[NS+1])
				out_valid_q <= vld_q[NS];
		end
	end

	assign vin[0][0] = in_ax;
	assign vin[0][1] = in_ay;
	assign vin[0][2] = in_az;
	assign vin[1][0] = in_bx;
	assign vin[1][1] = in_by;
	assign vin[1][2] = in_bz;
	assign vin[2][0] = in_cx;
	assign vin[2][1] = in_cy;
	assign vin[2][2] = in_cz;

	for (genvar l = 0; l < tcst_pkg::LANES; l++) begin : g_lane
		tcst_lane #(.COORD_WIDTH(COORD_WIDTH), .TRIG_WIDTH(TRIG_WIDTH)) u_lane (
			.clk        (clk),
			.ctrl       (ctrl),
			.x          (vin[l][0]),
			.y          (vin[l][1]),
			.z          (vin[l][2]),
			.off_x      (off_x_q),
			.off_y      (off_y_q),
			.off_z      (off_z_q),
			.yaw_trig   (yaw_q),
			.pitch_trig (pitch_q),
			.roll_trig  (roll_q),
			.rx         (vout[l][0]),
			.ry         (vout[l][1]),
			.rz         (vout[l][2])
		);
	end

	// merge the three lanes into one output word
	always_ff @(posedge clk) begin
		if (free[NS+1])
			res_q <= vout;
	end

	assign out_valid = out_valid_q;
	assign out_ax    = res_q[0][0];
	assign out_ay    = res_q[0][1];
	assign out_az    = res_q[0][2];
	assign out_bx    = res_q[1][0];
	assign out_by    = res_q[1][1];
	assign out_bz    = res_q[1][2];
	assign out_cx    = res_q[2][0];
	assign out_cy    = res_q[2][1];
	assign out_cz    = res_q[2][2];

`ifndef ASSERT_OFF
	a_full_refuses: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && (&vld_q)) |-> !in_ready)
		else $error("input accepted with every stage full and output stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[1])
		else $error("accepted word missing from first stage");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && vld_q[NS]) |=> vld_q[NS])
		else $error("last stage word dropped while output stalled");
`endif

endmodule

`default_nettype wire
